// ===== rtl/gtt_pkg.sv =====
// Shared constants, codes and arithmetic helpers for the twiddle gain tuner.
package gtt_pkg;

   localparam int unsigned GainW  = 32;
   localparam int unsigned ErrW   = 32;
   localparam int unsigned StepW  = 24;
   localparam int unsigned TolW   = 26;
   localparam int unsigned IdxW   = 3;
   localparam int unsigned CsrW   = 32;
   localparam int unsigned NumGains = 3;

   localparam logic [StepW-1:0] StepMax = {StepW{1'b1}};

   // request kinds
   localparam logic REQ_START  = 1'b0;
   localparam logic REQ_REPORT = 1'b1;

   // status codes
   localparam logic [1:0] ST_TRY     = 2'd0;
   localparam logic [1:0] ST_DONE    = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   // search phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_FIRST = 2'd1;
   localparam logic [1:0] PH_PLUS  = 2'd2;
   localparam logic [1:0] PH_MINUS = 2'd3;

   // register indexes
   localparam logic [IdxW-1:0] CSR_GAIN_P    = 3'd0;
   localparam logic [IdxW-1:0] CSR_GAIN_I    = 3'd1;
   localparam logic [IdxW-1:0] CSR_GAIN_D    = 3'd2;
   localparam logic [IdxW-1:0] CSR_INIT_STEP = 3'd3;
   localparam logic [IdxW-1:0] CSR_TOL       = 3'd4;

   localparam logic [StepW-1:0] InitStepReset = StepW'(1000);
   localparam logic [TolW-1:0]  TolReset      = TolW'(1);

   // floor(x / 10) for x below 2^32
   localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

   typedef logic signed [GainW-1:0] gain_type;
   typedef logic [StepW-1:0]        step_type;

   function automatic logic [StepW:0] div10(input logic [StepW:0] x);
      logic [StepW+32:0] prod;
      prod = (StepW+33)'(x) * (StepW+33)'(Recip10);
      return (StepW+1)'(prod >> 35);
   endfunction

   // s * 11 / 10, saturated
   function automatic step_type grow(input step_type s);
      logic [StepW:0] r;
      r = {1'b0, s} + div10({1'b0, s});
      return r[StepW] ? StepMax : r[StepW-1:0];
   endfunction

   // s * 9 / 10 = s - ceil(s / 10)
   function automatic step_type shrink(input step_type s);
      logic [StepW:0] q;
      q = div10({1'b0, s} + (StepW+1)'(9));
      return s - q[StepW-1:0];
   endfunction

   function automatic gain_type sat_add(input gain_type g, input logic signed [StepW+1:0] d);
      logic signed [GainW+1:0] r;
      r = (GainW+2)'(g) + (GainW+2)'(d);
      if (r > (GainW+2)'(signed'({1'b0, {(GainW-1){1'b1}}})))
         return {1'b0, {(GainW-1){1'b1}}};
      else if (r < -(GainW+2)'(signed'({1'b0, 1'b1, {(GainW-1){1'b0}}})))
         return {1'b1, {(GainW-1){1'b0}}};
      else
         return r[GainW-1:0];
   endfunction

endpackage

// ===== rtl/gain_twiddle_tuner_unit.sv =====
// Twiddle coordinate-descent tuner for three PID gains, top level.
// Path: request word to the input register, result word to the result register.
// Throughput: one word per cycle unless rsp_tready stalls; each report is
//   decided in a single pass between the input and result registers.
// Reset: synchronous, active high; clears the pipeline, sets the search idle,
//   gains and steps to zero, best error to all ones, registers to defaults.
module gain_twiddle_tuner_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // trial_error
   input  logic         req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // gain_p, gain_i, gain_d, best_error
   output logic [1:0]   rsp_tuser,   // status
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int unsigned StepW = gtt_pkg::StepW;

   // configuration
   gtt_pkg::gain_type             init_ff [gtt_pkg::NumGains];
   gtt_pkg::step_type             init_step_ff;
   logic [gtt_pkg::TolW-1:0]      tol_ff;

   // input register
   logic                          in_valid_ff;
   logic                          in_type_ff;
   logic [gtt_pkg::ErrW-1:0]      in_err_ff;

   // search state
   gtt_pkg::gain_type             gains_ff [gtt_pkg::NumGains];
   gtt_pkg::step_type             steps_ff [gtt_pkg::NumGains];
   logic [gtt_pkg::ErrW-1:0]      low_ff;
   logic [1:0]                    coord_ff;
   logic [1:0]                    phase_ff;

   gtt_pkg::gain_type             gains_in [gtt_pkg::NumGains];
   gtt_pkg::step_type             steps_in [gtt_pkg::NumGains];
   logic [gtt_pkg::ErrW-1:0]      low_in;
   logic [1:0]                    coord_in;
   logic [1:0]                    phase_in;
   logic [1:0]                    status_in;

   // result register
   logic                          out_valid_ff;
   logic [127:0]                  out_data_ff;
   logic [1:0]                    out_status_ff;

   logic                          out_free;
   logic                          fire;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff[0]   <= '0;
         init_ff[1]   <= '0;
         init_ff[2]   <= '0;
         init_step_ff <= gtt_pkg::InitStepReset;
         tol_ff       <= gtt_pkg::TolReset;
      end else if (csr_we) begin
         unique case (csr_index)
            gtt_pkg::CSR_GAIN_P:    init_ff[0]   <= csr_wdata;
            gtt_pkg::CSR_GAIN_I:    init_ff[1]   <= csr_wdata;
            gtt_pkg::CSR_GAIN_D:    init_ff[2]   <= csr_wdata;
            gtt_pkg::CSR_INIT_STEP: init_step_ff <= csr_wdata[StepW-1:0];
            gtt_pkg::CSR_TOL:       tol_ff       <= csr_wdata[gtt_pkg::TolW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_type_ff <= req_tuser;
         in_err_ff  <= req_tdata;
      end
   end

   always_comb begin
      logic [1:0]                    c;
      logic [1:0]                    cn;
      logic                          better;
      logic                          do_adv;
      logic                          do_pass;
      logic [gtt_pkg::TolW-1:0]      total;
      gtt_pkg::step_type             s_c;

      for (int k = 0; k < gtt_pkg::NumGains; k++) begin
         gains_in[k] = gains_ff[k];
         steps_in[k] = steps_ff[k];
      end
      low_in    = low_ff;
      coord_in  = coord_ff;
      phase_in  = phase_ff;
      status_in = gtt_pkg::ST_TRY;
      c         = coord_ff;
      cn        = c + 2'd1;
      better    = in_err_ff < low_ff;
      do_adv    = 1'b0;
      do_pass   = 1'b0;
      s_c       = '0;
      total     = '0;

      if (in_type_ff == gtt_pkg::REQ_START) begin
         for (int k = 0; k < gtt_pkg::NumGains; k++) begin
            gains_in[k] = init_ff[k];
            steps_in[k] = init_step_ff;
         end
         low_in   = '1;
         coord_in = 2'd0;
         phase_in = gtt_pkg::PH_FIRST;
      end else if (phase_ff == gtt_pkg::PH_IDLE) begin
         status_in = gtt_pkg::ST_IGNORED;
      end else if (phase_ff == gtt_pkg::PH_FIRST) begin
         low_in  = in_err_ff;
         do_pass = 1'b1;
      end else if (c == 2'd3) begin
         do_pass = 1'b1;
      end else begin
         s_c = steps_ff[c];
         if (better) begin
            low_in      = in_err_ff;
            steps_in[c] = gtt_pkg::grow(s_c);
            do_adv      = 1'b1;
         end else if (phase_ff == gtt_pkg::PH_PLUS) begin
            gains_in[c] = gtt_pkg::sat_add(gains_ff[c], -((StepW+2)'(s_c) <<< 1));
            phase_in    = gtt_pkg::PH_MINUS;
         end else begin
            gains_in[c] = gtt_pkg::sat_add(gains_ff[c], (StepW+2)'(s_c));
            steps_in[c] = gtt_pkg::shrink(s_c);
            do_adv      = 1'b1;
         end
      end

      if (do_adv) begin
         if (cn < 2'd3) begin
            coord_in     = cn;
            gains_in[cn] = gtt_pkg::sat_add(gains_ff[cn], (StepW+2)'(steps_ff[cn]));
            phase_in     = gtt_pkg::PH_PLUS;
         end else begin
            do_pass = 1'b1;
         end
      end

      if (do_pass) begin
         total = gtt_pkg::TolW'(steps_in[0]) + gtt_pkg::TolW'(steps_in[1])
               + gtt_pkg::TolW'(steps_in[2]);
         if (total > tol_ff) begin
            coord_in    = 2'd0;
            gains_in[0] = gtt_pkg::sat_add(gains_in[0], (StepW+2)'(steps_in[0]));
            phase_in    = gtt_pkg::PH_PLUS;
         end else begin
            phase_in  = gtt_pkg::PH_IDLE;
            status_in = gtt_pkg::ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < gtt_pkg::NumGains; k++) begin
            gains_ff[k] <= '0;
            steps_ff[k] <= '0;
         end
         low_ff       <= '1;
         coord_ff     <= 2'd0;
         phase_ff     <= gtt_pkg::PH_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            for (int k = 0; k < gtt_pkg::NumGains; k++) begin
               gains_ff[k] <= gains_in[k];
               steps_ff[k] <= steps_in[k];
            end
            low_ff   <= low_in;
            coord_ff <= coord_in;
            phase_ff <= phase_in;
         end
      end
      if (fire) begin
         out_data_ff   <= {low_in, gains_in[2], gains_in[1], gains_in[0]};
         out_status_ff <= status_in;
      end
   end

endmodule
